[sv/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Types and codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OP_W   = 16;
  localparam int unsigned NUM_W  = 34;
  localparam int unsigned DEN_W  = 32;
  localparam int unsigned WORK_W = 64;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_SQR = 3'd4;

  typedef struct packed {
    logic [2:0]             func;
    logic signed [OP_W-1:0] a_num;
    logic signed [OP_W-1:0] a_den;
    logic signed [OP_W-1:0] b_num;
    logic signed [OP_W-1:0] b_den;
  } in_req_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic signed [DEN_W-1:0] res_den;
    logic                    den_zero;
  } out_req_t;

  // datapath commands
  typedef struct packed {
    logic load;      // capture operands
    logic mul;       // one product step
    logic form;      // form raw terms
    logic div_start; // start a divide
    logic [1:0] div_sel; // 0 euclid rem, 1 num quo, 2 den quo
    logic div_step;
    logic gcd_shift; // x<=y, y<=rem
    logic emit;      // load output register
  } rau_cmd_t;

  typedef struct packed {
    logic num_zero;
    logic y_zero;
    logic div_done;
  } rau_sts_t;

  localparam logic [1:0] DSEL_REM  = 2'd0;
  localparam logic [1:0] DSEL_QNUM = 2'd1;
  localparam logic [1:0] DSEL_QDEN = 2'd2;

endpackage

[sv/rau_divider.sv]
// ----------------------------------------------------------------------------
// rau_divider
// Radix-2 restoring divider on 64-bit magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rau_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rau_pkg::WORK_W-1:0]  dividend,
  input  logic [rau_pkg::WORK_W-1:0]  divisor,
  output logic                        done,
  output logic [rau_pkg::WORK_W-1:0]  quo,
  output logic [rau_pkg::WORK_W-1:0]  rem
);
  import rau_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORK_W + 1);

  logic [WORK_W-1:0] q_r, r_r, d_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [WORK_W:0]   trial;
  logic [WORK_W:0]   shifted;

  assign shifted = {r_r, q_r[WORK_W-1]};
  assign trial   = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(WORK_W);
      q_r    <= dividend;
      r_r    <= '0;
      d_r    <= divisor;
    end else if (busy_r) begin
      if (trial[WORK_W]) begin
        r_r <= shifted[WORK_W-1:0];
        q_r <= {q_r[WORK_W-2:0], 1'b0};
      end else begin
        r_r <= trial[WORK_W-1:0];
        q_r <= {q_r[WORK_W-2:0], 1'b1};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  assign done = !busy_r && !start;
  assign quo  = q_r;
  assign rem  = r_r;
endmodule

[sv/rau_datapath.sv]
// ----------------------------------------------------------------------------
// rau_datapath
// Operand products, Euclid registers, shared divider and output register.
// ----------------------------------------------------------------------------
module rau_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [2:0]                        func,
  input  logic signed [rau_pkg::OP_W-1:0]   a_num,
  input  logic signed [rau_pkg::OP_W-1:0]   a_den,
  input  logic signed [rau_pkg::OP_W-1:0]   b_num,
  input  logic signed [rau_pkg::OP_W-1:0]   b_den,
  input  rau_pkg::rau_cmd_t                 cmd,
  output rau_pkg::rau_sts_t                 sts,
  output logic signed [rau_pkg::NUM_W-1:0]  res_num,
  output logic signed [rau_pkg::DEN_W-1:0]  res_den
);
  import rau_pkg::*;

  localparam int unsigned PW = 2 * OP_W;

  logic [2:0]                      func_r;
  logic signed [OP_W-1:0]          an_r, ad_r, bn_r, bd_r;
  logic signed [PW-1:0]            p_r [4];
  logic [1:0]                      pidx_r;
  logic [WORK_W-1:0]               n_r, d_r, x_r, y_r;
  logic [WORK_W-1:0]               n_nxt, d_nxt;
  logic signed [OP_W-1:0]          ma, mb;
  logic signed [PW-1:0]            prod;
  logic [WORK_W-1:0]               p0, p1, p2, p3;
  logic [WORK_W-1:0]               dvd, dvs, quo, rem;
  logic                            dvd_neg, dvs_neg;
  logic                            dv_done;
  logic [WORK_W-1:0]               q_signed;
  logic signed [NUM_W-1:0]         rn_r;
  logic signed [DEN_W-1:0]         rd_r;

  function automatic logic [WORK_W-1:0] mag(input logic [WORK_W-1:0] v);
    return v[WORK_W-1] ? (WORK_W'(0) - v) : v;
  endfunction

  // products: 0 an*bd, 1 ad*bn, 2 an*bn, 3 ad*bd (square: an*an, ad*ad)
  always_comb begin
    case (pidx_r)
      2'd0: begin ma = an_r; mb = (func_r == FUNC_SQR) ? an_r : bd_r; end
      2'd1: begin ma = ad_r; mb = bn_r; end
      2'd2: begin ma = an_r; mb = (func_r == FUNC_SQR) ? an_r : bn_r; end
      default: begin ma = ad_r; mb = (func_r == FUNC_SQR) ? ad_r : bd_r; end
    endcase
    prod = ma * mb;
  end

  assign p0 = WORK_W'(p_r[0]);
  assign p1 = WORK_W'(p_r[1]);
  assign p2 = WORK_W'(p_r[2]);
  assign p3 = WORK_W'(p_r[3]);

  always_comb begin
    case (func_r)
      FUNC_ADD: begin n_nxt = p0 + p1; d_nxt = p3; end
      FUNC_SUB: begin n_nxt = p0 - p1; d_nxt = p3; end
      FUNC_MUL: begin n_nxt = p2;      d_nxt = p3; end
      FUNC_DIV: begin n_nxt = p0;      d_nxt = p1; end
      FUNC_SQR: begin n_nxt = p2;      d_nxt = p3; end
      default:  begin n_nxt = '0;      d_nxt = WORK_W'(1); end
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DSEL_REM:  begin dvd = x_r; dvs = y_r; end
      DSEL_QNUM: begin dvd = n_r; dvs = x_r; end
      default:   begin dvd = d_r; dvs = x_r; end
    endcase
  end

  rau_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag(dvd)),
    .divisor  (mag(dvs)),
    .done     (dv_done),
    .quo      (quo),
    .rem      (rem)
  );

  logic [WORK_W-1:0] rem_signed;
  logic              sel_dvd_neg, sel_dvs_neg;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sel_dvd_neg <= dvd[WORK_W-1];
      sel_dvs_neg <= dvs[WORK_W-1];
    end
  end

  assign dvd_neg    = sel_dvd_neg;
  assign dvs_neg    = sel_dvs_neg;
  assign rem_signed = dvd_neg ? (WORK_W'(0) - rem) : rem;
  assign q_signed   = (dvd_neg != dvs_neg) ? (WORK_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      an_r   <= a_num;
      ad_r   <= a_den;
      bn_r   <= b_num;
      bd_r   <= b_den;
      pidx_r <= '0;
    end
    if (cmd.mul) begin
      p_r[pidx_r] <= prod;
      pidx_r      <= pidx_r + 2'd1;
    end
    if (cmd.form) begin
      n_r <= n_nxt;
      d_r <= d_nxt;
      x_r <= mag(n_nxt);
      y_r <= d_nxt;
    end
    if (cmd.gcd_shift) begin
      x_r <= y_r;
      y_r <= rem_signed;
    end
    if (cmd.div_step) begin
      if (cmd.div_sel == DSEL_QNUM) n_r <= q_signed;
      else if (cmd.div_sel == DSEL_QDEN) d_r <= q_signed;
    end
    if (cmd.emit) begin
      rn_r <= NUM_W'(n_r);
      rd_r <= DEN_W'(d_r);
    end
  end

  assign sts.num_zero = (n_r == '0);
  assign sts.y_zero   = (y_r == '0);
  assign sts.div_done = dv_done;
  assign res_num      = rn_r;
  assign res_den      = rd_r;
endmodule

[sv/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: products, Euclid loop, two quotients, output handshake.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rau_pkg::rau_sts_t sts,
  output rau_pkg::rau_cmd_t cmd
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_FORM, S_CHK, S_REM_GO, S_REM_WAIT,
    S_QN_GO, S_QN_WAIT, S_QD_GO, S_QD_WAIT, S_EMIT
  } state_t;

  state_t     state_r;
  logic [1:0] mcnt_r;
  logic       ov_r;
  logic       ov_nxt;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:     cmd.load = in_valid;
      S_MUL:      cmd.mul = 1'b1;
      S_FORM:     cmd.form = 1'b1;
      S_REM_GO:   begin cmd.div_start = 1'b1; cmd.div_sel = DSEL_REM; end
      S_REM_WAIT: begin cmd.div_sel = DSEL_REM; cmd.gcd_shift = sts.div_done; end
      S_QN_GO:    begin cmd.div_start = 1'b1; cmd.div_sel = DSEL_QNUM; end
      S_QN_WAIT:  begin cmd.div_sel = DSEL_QNUM; cmd.div_step = sts.div_done; end
      S_QD_GO:    begin cmd.div_start = 1'b1; cmd.div_sel = DSEL_QDEN; end
      S_QD_WAIT:  begin cmd.div_sel = DSEL_QDEN; cmd.div_step = sts.div_done; end
      S_EMIT:     cmd.emit = !ov_r || !out_stall;
      default:    cmd = '0;
    endcase
  end

  // in S_EMIT the output register is either kept or reloaded, so it stays full
  assign ov_nxt = (state_r == S_EMIT) || (ov_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      case (state_r)
        S_IDLE: if (in_valid) begin state_r <= S_MUL; mcnt_r <= '0; end
        S_MUL: begin
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd3) state_r <= S_FORM;
        end
        S_FORM: state_r <= S_CHK;
        S_CHK: begin
          if (sts.num_zero)    state_r <= S_EMIT;
          else if (sts.y_zero) state_r <= S_QN_GO;
          else                 state_r <= S_REM_GO;
        end
        S_REM_GO:   state_r <= S_REM_WAIT;
        S_REM_WAIT: if (sts.div_done) state_r <= S_CHK;
        S_QN_GO:    state_r <= S_QN_WAIT;
        S_QN_WAIT:  if (sts.div_done) state_r <= S_QD_GO;
        S_QD_GO:    state_r <= S_QD_WAIT;
        S_QD_WAIT:  if (sts.div_done) state_r <= S_EMIT;
        S_EMIT: if (!ov_r || !out_stall) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
endmodule

[sv/rational_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Rational add/sub/mul/div/square with Euclid GCD reduction.
// ----------------------------------------------------------------------------
// channel | ports                          | request
// in      | in_valid, in_stall, in_data    | func, a_num, a_den, b_num, b_den
// out     | out_valid, out_stall, out_data | res_num, res_den, den_zero
//
// One request at a time: four products and a form step, then per Euclid step
// (check, start, 64 bit steps, done) on the shared bit-serial divider, then a
// final check and one quotient divide each for numerator and denominator
// before out_valid rises; a zero numerator goes from the check to the output.
// The output register lets the next request start while a result waits.
// rst_n synchronous, active low. in_stall is high while a request is at work.
module rational_arithmetic_unit_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rau_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rau_pkg::out_req_t out_data
);
  import rau_pkg::*;

  rau_cmd_t cmd;
  rau_sts_t sts;
  logic signed [NUM_W-1:0] rn;
  logic signed [DEN_W-1:0] rd;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  rau_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .func(in_data.func),
    .a_num(in_data.a_num), .a_den(in_data.a_den),
    .b_num(in_data.b_num), .b_den(in_data.b_den),
    .cmd(cmd), .sts(sts), .res_num(rn), .res_den(rd)
  );

  assign out_data.res_num  = rn;
  assign out_data.res_den  = rd;
  assign out_data.den_zero = (rd == '0);
endmodule

[sv/rau_checker.sv]
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rau_pkg::out_req_t out_data
);
  import rau_pkg::*;

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.den_zero == (out_data.res_den == '0)))
    else $error("den_zero mismatch");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("reset state");
endmodule

bind rational_arithmetic_unit_top rau_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[dv/tb_rational_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit_top
// Self-checking bench for the rational arithmetic unit: a short table of
// directed requests, then random ones, each result checked against a
// predicted reduced fraction, with random idling, random stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit_top;
  import rau_pkg::*;

  localparam int unsigned RANDOM_REQS = 1630;
  localparam longint unsigned CYCLE_LIMIT = 64'd30_000_000;
  localparam int unsigned LONG_HOLD = 20000;
  localparam logic [2:0] FUNC_RSV5 = 3'd5;
  localparam logic [2:0] FUNC_RSV6 = 3'd6;
  localparam logic [2:0] FUNC_RSV7 = 3'd7;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_req_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_req_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_req_t  out_data;

  out_req_t  expected_results[$];
  int unsigned  mismatches = 0;
  int unsigned  sent_count = 0;
  longint unsigned cycles = 0;
  bit        quiet = 1'b0;
  bit        hold_done = 1'b0;
  int unsigned hold_left = 0;

  rational_arithmetic_unit_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] magn(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic [63:0] trunc_rem(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = magn(a) % magn(b);
    return a[63] ? 64'd0 - r : r;
  endfunction

  function automatic logic [63:0] trunc_quo(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    q = magn(a) / magn(b);
    return (a[63] != b[63]) ? 64'd0 - q : q;
  endfunction

  function automatic out_req_t reduced_fraction(in_req_t r);
    logic [63:0] an, ad, bn, bd, n, d, x, y, t;
    out_req_t o;
    an = {{48{r.a_num[15]}}, r.a_num};
    ad = {{48{r.a_den[15]}}, r.a_den};
    bn = {{48{r.b_num[15]}}, r.b_num};
    bd = {{48{r.b_den[15]}}, r.b_den};
    case (r.func)
      FUNC_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
      FUNC_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
      FUNC_MUL: begin n = an * bn; d = ad * bd; end
      FUNC_DIV: begin n = an * bd; d = ad * bn; end
      FUNC_SQR: begin n = an * an; d = ad * ad; end
      default: begin n = 64'd0; d = 64'd1; end
    endcase
    if (n != 64'd0) begin
      x = magn(n);
      y = d;
      while (y != 64'd0) begin
        t = trunc_rem(x, y);
        x = y;
        y = t;
      end
      n = trunc_quo(n, x);
      d = trunc_quo(d, x);
    end
    o.res_num = n[NUM_W-1:0];
    o.res_den = d[DEN_W-1:0];
    o.den_zero = (d[DEN_W-1:0] == '0);
    return o;
  endfunction

  task automatic report_mismatch(string field, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0d got %0d", field, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_req_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected request res_num", 0, out_data.res_num);
      end else begin
        e = expected_results.pop_front();
        if (out_data.res_num !== e.res_num)
          report_mismatch("res_num", e.res_num, out_data.res_num);
        if (out_data.res_den !== e.res_den)
          report_mismatch("res_den", e.res_den, out_data.res_den);
        if (out_data.den_zero !== e.den_zero)
          report_mismatch("den_zero", e.den_zero, out_data.den_zero);
      end
    end
  end

  // receiver: random stall, one long hold-off while the sender keeps going
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= 400) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 11);
      end
    end
  end

  task automatic send_request(in_req_t req, bit typed, out_req_t res);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(typed ? res : reduced_fraction(req));
    sent_count++;
    if (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic in_req_t make_req(logic [2:0] f, int an, int ad, int bn, int bd);
    in_req_t r;
    r.func = f;
    r.a_num = an[15:0];
    r.a_den = ad[15:0];
    r.b_num = bn[15:0];
    r.b_den = bd[15:0];
    return r;
  endfunction

  function automatic out_req_t make_res(longint n, longint d, bit z);
    out_req_t o;
    o.res_num = n[NUM_W-1:0];
    o.res_den = d[DEN_W-1:0];
    o.den_zero = z;
    return o;
  endfunction

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1, 2: return 16'($signed($urandom_range(0, 40)) - 20);
      3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    dir_row_t rows[$];
    in_req_t r;
    out_req_t none;
    none = '0;
    rows.push_back('{make_req(FUNC_ADD, 0, 1, 0, 1), 1'b1, make_res(0, 1, 1'b0)});
    rows.push_back('{make_req(FUNC_DIV, 3, 4, 0, 5), 1'b1, make_res(1, 0, 1'b1)});
    rows.push_back('{make_req(FUNC_DIV, -3, 4, 0, 5), 1'b1, make_res(-1, 0, 1'b1)});
    rows.push_back('{make_req(FUNC_SQR, 0, 0, 7, 9), 1'b1, make_res(0, 0, 1'b1)});
    rows.push_back('{make_req(FUNC_MUL, -32768, 1, -32768, 1), 1'b1,
                     make_res(1073741824, 1, 1'b0)});
    rows.push_back('{make_req(FUNC_SQR, -32768, -32768, 0, 0), 1'b1,
                     make_res(1, 1, 1'b0)});
    rows.push_back('{make_req(FUNC_RSV5, 5, 6, 7, 8), 1'b1, make_res(0, 1, 1'b0)});
    rows.push_back('{make_req(FUNC_RSV6, -1, -1, -1, -1), 1'b1, make_res(0, 1, 1'b0)});
    rows.push_back('{make_req(FUNC_RSV7, 32767, -32768, 1, 0), 1'b1,
                     make_res(0, 1, 1'b0)});
    rows.push_back('{make_req(FUNC_ADD, 1, 2, 1, 3), 1'b0, none});
    rows.push_back('{make_req(FUNC_SUB, 1, 2, 1, 2), 1'b0, none});
    rows.push_back('{make_req(FUNC_SUB, 1, -2, 3, 4), 1'b0, none});
    rows.push_back('{make_req(FUNC_MUL, 6, -4, -10, 15), 1'b0, none});
    rows.push_back('{make_req(FUNC_DIV, 2, 3, -4, 9), 1'b0, none});
    rows.push_back('{make_req(FUNC_DIV, 0, 3, 0, 9), 1'b0, none});
    rows.push_back('{make_req(FUNC_SQR, -12, 18, 32767, -32768), 1'b0, none});
    rows.push_back('{make_req(FUNC_ADD, 32767, 32767, 32767, 32767), 1'b0, none});
    rows.push_back('{make_req(FUNC_ADD, -32768, -32768, -32768, -32768), 1'b0, none});
    rows.push_back('{make_req(FUNC_SUB, 32767, -32768, -32768, 32767), 1'b0, none});
    rows.push_back('{make_req(FUNC_MUL, 32767, -32768, 32767, 32767), 1'b0, none});
    rows.push_back('{make_req(FUNC_DIV, -32768, 32767, 32767, -32768), 1'b0, none});
    rows.push_back('{make_req(FUNC_ADD, 5, 0, 3, 0), 1'b0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == 600) begin
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      quiet = (i >= 900 && i < 1100);
      r.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
      r.a_num = rand_operand();
      r.a_den = rand_operand();
      r.b_num = rand_operand();
      r.b_den = rand_operand();
      send_request(r, 1'b0, none);
    end
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3500) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
sv/rau_pkg.sv
sv/rau_divider.sv
sv/rau_datapath.sv
sv/rau_ctrl.sv
sv/rational_arithmetic_unit_top.sv
sv/rau_checker.sv
dv/tb_rational_arithmetic_unit_top.sv
